>>> hdl/ifgd_pkg.sv
// shared types and constants for the imu/gps frame decoder
// no dependencies; used by every module under hdl
package ifgd_pkg;

    localparam int MAX_PAYLOAD  = 28;
    // only the first payload bytes are ever decoded into fields
    localparam int DECODE_BYTES = 14;
    localparam int IDX_W        = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] HDR0       = 8'h44;
    localparam logic [7:0] HDR1       = 8'h49;
    localparam logic [7:0] HDR2       = 8'h59;
    localparam logic [7:0] HDR3       = 8'h64;
    localparam logic [7:0] MSG_ATT    = 8'h02;
    localparam logic [7:0] MSG_GPS    = 8'h03;
    localparam logic [7:0] MSG_ATT_AS = 8'h04;
    localparam logic [7:0] MSG_PERF   = 8'h0a;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_HDR1 = 4'd1,
        PH_HDR2 = 4'd2,
        PH_HDR3 = 4'd3,
        PH_LEN  = 4'd4,
        PH_MSG  = 4'd5,
        PH_PAY  = 4'd6,
        PH_CHK0 = 4'd7,
        PH_CHK1 = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        EV_ATT     = 3'd0,
        EV_ATT_AS  = 3'd1,
        EV_GPS     = 3'd2,
        EV_PERF    = 3'd3,
        EV_UNKNOWN = 3'd4,
        EV_CHK_ERR = 3'd5,
        EV_LEN_ERR = 3'd6
    } event_t;

    typedef logic [DECODE_BYTES-1:0][7:0] payload_bytes_t;

    // frame end report from the parser to the field unpacker
    typedef struct packed {
        logic       fire;
        logic       len_err;
        logic       chk_err;
        logic [7:0] msg;
    } frame_end_t;

endpackage

>>> hdl/ifgd_frame_fsm.sv
// header hunt, length/number/payload parse and fletcher-8 sums
// depends on ifgd_pkg
module ifgd_frame_fsm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              rx,
    output ifgd_pkg::frame_end_t    done,
    output ifgd_pkg::payload_bytes_t store
);

    ifgd_pkg::phase_t                phase_reg, phase_next;
    logic [ifgd_pkg::IDX_W-1:0]      frame_length_reg, frame_length_next;
    logic [ifgd_pkg::IDX_W-1:0]      byte_index_reg, byte_index_next;
    logic [ifgd_pkg::IDX_W-1:0]      idx_inc;
    logic [7:0]                      message_kind_reg, message_kind_next;
    logic [7:0]                      sum_a_reg, sum_a_next;
    logic [7:0]                      sum_b_reg, sum_b_next;
    logic [7:0]                      first_check_reg, first_check_next;
    logic [7:0]                      sum_a_add, sum_b_add;
    logic                            len_bad;
    ifgd_pkg::payload_bytes_t        store_reg, store_next;

    assign sum_a_add = sum_a_reg + rx;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign len_bad   = rx > 8'(ifgd_pkg::MAX_PAYLOAD);
    assign idx_inc   = byte_index_reg + 1'b1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                ifgd_pkg::PH_HDR1: phase_next = (rx == ifgd_pkg::HDR1) ? ifgd_pkg::PH_HDR2
                                                                      : ifgd_pkg::PH_HUNT;
                ifgd_pkg::PH_HDR2: phase_next = (rx == ifgd_pkg::HDR2) ? ifgd_pkg::PH_HDR3
                                                                      : ifgd_pkg::PH_HUNT;
                ifgd_pkg::PH_HDR3: phase_next = (rx == ifgd_pkg::HDR3) ? ifgd_pkg::PH_LEN
                                                                      : ifgd_pkg::PH_HUNT;
                ifgd_pkg::PH_LEN:  phase_next = len_bad ? ifgd_pkg::PH_HUNT : ifgd_pkg::PH_MSG;
                ifgd_pkg::PH_MSG:  phase_next = ifgd_pkg::PH_PAY;
                ifgd_pkg::PH_PAY:  phase_next = (idx_inc >= frame_length_reg)
                                                ? ifgd_pkg::PH_CHK0 : ifgd_pkg::PH_PAY;
                ifgd_pkg::PH_CHK0: phase_next = ifgd_pkg::PH_CHK1;
                ifgd_pkg::PH_CHK1: phase_next = ifgd_pkg::PH_HUNT;
                default:           phase_next = (rx == ifgd_pkg::HDR0) ? ifgd_pkg::PH_HDR1
                                                                      : ifgd_pkg::PH_HUNT;
            endcase
        end
    end

    // frame bookkeeping, sums and payload store
    always_comb
    begin
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        message_kind_next = message_kind_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        first_check_next  = first_check_reg;
        store_next        = store_reg;
        if (step)
        begin
            case (phase_reg)
                ifgd_pkg::PH_LEN:
                begin
                    if (len_bad)
                    begin
                        sum_a_next      = '0;
                        sum_b_next      = '0;
                        byte_index_next = '0;
                    end
                    else
                    begin
                        frame_length_next = rx[ifgd_pkg::IDX_W-1:0];
                        sum_a_next        = sum_a_add;
                        sum_b_next        = sum_b_add;
                    end
                end
                ifgd_pkg::PH_MSG:
                begin
                    message_kind_next = rx;
                    sum_a_next        = sum_a_add;
                    sum_b_next        = sum_b_add;
                end
                ifgd_pkg::PH_PAY:
                begin
                    // bytes past the decoded window are never read back
                    for (int i = 0; i < ifgd_pkg::DECODE_BYTES; i++)
                    begin
                        if (byte_index_reg == ifgd_pkg::IDX_W'(i))
                        begin
                            store_next[i] = rx;
                        end
                    end
                    sum_a_next      = sum_a_add;
                    sum_b_next      = sum_b_add;
                    byte_index_next = idx_inc;
                end
                ifgd_pkg::PH_CHK0:
                begin
                    first_check_next = rx;
                end
                ifgd_pkg::PH_CHK1:
                begin
                    sum_a_next      = '0;
                    sum_b_next      = '0;
                    byte_index_next = '0;
                end
                default:
                begin
                    sum_a_next = sum_a_reg;
                end
            endcase
        end
    end

    // frame end report for the current beat
    always_comb
    begin
        done.fire    = (phase_reg == ifgd_pkg::PH_LEN && len_bad)
                       || phase_reg == ifgd_pkg::PH_CHK1;
        done.len_err = phase_reg == ifgd_pkg::PH_LEN;
        done.chk_err = (sum_a_reg != first_check_reg) || (sum_b_reg != rx);
        done.msg     = message_kind_reg;
    end

    assign store = store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ifgd_pkg::PH_HUNT;
            frame_length_reg <= '0;
            byte_index_reg   <= '0;
            message_kind_reg <= '0;
            sum_a_reg        <= '0;
            sum_b_reg        <= '0;
            first_check_reg  <= '0;
            store_reg        <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_index_reg   <= byte_index_next;
            message_kind_reg <= message_kind_next;
            sum_a_reg        <= sum_a_next;
            sum_b_reg        <= sum_b_next;
            first_check_reg  <= first_check_next;
            store_reg        <= store_next;
        end
    end

endmodule

>>> hdl/ifgd_field_unpack.sv
// turns a frame end report and the stored payload into event and fields
// depends on ifgd_pkg
module ifgd_field_unpack (
    input  ifgd_pkg::frame_end_t      done,
    input  ifgd_pkg::payload_bytes_t  store,
    output logic [2:0]                event_res,
    output logic signed [15:0]        roll,
    output logic signed [15:0]        pitch,
    output logic signed [15:0]        yaw,
    output logic signed [15:0]        airspeed,
    output logic signed [31:0]        longitude,
    output logic signed [31:0]        latitude,
    output logic signed [15:0]        altitude,
    output logic signed [15:0]        ground_speed,
    output logic signed [15:0]        course
);

    ifgd_pkg::event_t ev;

    always_comb
    begin
        ev           = ifgd_pkg::EV_UNKNOWN;
        roll         = '0;
        pitch        = '0;
        yaw          = '0;
        airspeed     = '0;
        longitude    = '0;
        latitude     = '0;
        altitude     = '0;
        ground_speed = '0;
        course       = '0;
        if (done.len_err)
        begin
            ev = ifgd_pkg::EV_LEN_ERR;
        end
        else if (done.chk_err)
        begin
            ev = ifgd_pkg::EV_CHK_ERR;
        end
        else
        begin
            case (done.msg)
                ifgd_pkg::MSG_ATT, ifgd_pkg::MSG_ATT_AS:
                begin
                    roll  = {store[0], store[1]};
                    pitch = {store[2], store[3]};
                    yaw   = {store[4], store[5]};
                    if (done.msg == ifgd_pkg::MSG_ATT)
                    begin
                        ev       = ifgd_pkg::EV_ATT;
                        airspeed = 16'hffff;
                    end
                    else
                    begin
                        ev       = ifgd_pkg::EV_ATT_AS;
                        airspeed = {store[6], store[7]};
                    end
                end
                ifgd_pkg::MSG_GPS:
                begin
                    ev           = ifgd_pkg::EV_GPS;
                    longitude    = {store[0], store[1], store[2], store[3]};
                    latitude     = {store[4], store[5], store[6], store[7]};
                    altitude     = {store[8], store[9]};
                    ground_speed = {store[10], store[11]};
                    course       = {store[12], store[13]};
                end
                ifgd_pkg::MSG_PERF:
                begin
                    ev = ifgd_pkg::EV_PERF;
                end
                default:
                begin
                    ev = ifgd_pkg::EV_UNKNOWN;
                end
            endcase
        end
    end

    assign event_res = ev;

endmodule

>>> hdl/imu_gps_frame_decoder_unit.sv
// top level of the imu/gps frame decoder: input register, parser, result register
// depends on ifgd_pkg, ifgd_frame_fsm, ifgd_field_unpack
//
//  port group   direction  beat carries
//  in_*         sink       rx_byte, one received serial byte
//  out_*        source     event_res and decoded fields, one per frame end
//
// one byte per cycle sustained while no frame-ending byte waits on a full
// result register; a byte is held in the input register, and the parse step
// that takes it from there also loads the result register, so a result is
// offered once the last check byte (or a bad length byte) is parsed
// reset clears the parser to header hunt and the payload store to zero
// a stall on out_ready holds input only when a byte that ends a frame waits
// behind a full result register; other bytes keep flowing
module imu_gps_frame_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         event_res,
    output logic signed [15:0] roll,
    output logic signed [15:0] pitch,
    output logic signed [15:0] yaw,
    output logic signed [15:0] airspeed,
    output logic signed [31:0] longitude,
    output logic signed [31:0] latitude,
    output logic signed [15:0] altitude,
    output logic signed [15:0] ground_speed,
    output logic signed [15:0] course
);

    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               byte_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     advance;
    ifgd_pkg::frame_end_t     done;
    ifgd_pkg::payload_bytes_t store;

    logic [2:0]         ev_w;
    logic signed [15:0] roll_w, pitch_w, yaw_w, airspeed_w;
    logic signed [31:0] longitude_w, latitude_w;
    logic signed [15:0] altitude_w, ground_speed_w, course_w;

    logic [2:0]         event_reg;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg, airspeed_reg;
    logic signed [31:0] longitude_reg, latitude_reg;
    logic signed [15:0] altitude_reg, ground_speed_reg, course_reg;

    ifgd_frame_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .rx    (byte_reg),
        .done  (done),
        .store (store)
    );

    ifgd_field_unpack u_unpack (
        .done         (done),
        .store        (store),
        .event_res    (ev_w),
        .roll         (roll_w),
        .pitch        (pitch_w),
        .yaw          (yaw_w),
        .airspeed     (airspeed_w),
        .longitude    (longitude_w),
        .latitude     (latitude_w),
        .altitude     (altitude_w),
        .ground_speed (ground_speed_w),
        .course       (course_w)
    );

    // a held byte moves on unless it ends a frame and the result slot is full
    assign advance  = in_valid_reg && (!done.fire || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && done.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && done.fire)
        begin
            event_reg        <= ev_w;
            roll_reg         <= roll_w;
            pitch_reg        <= pitch_w;
            yaw_reg          <= yaw_w;
            airspeed_reg     <= airspeed_w;
            longitude_reg    <= longitude_w;
            latitude_reg     <= latitude_w;
            altitude_reg     <= altitude_w;
            ground_speed_reg <= ground_speed_w;
            course_reg       <= course_w;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign roll         = roll_reg;
    assign pitch        = pitch_reg;
    assign yaw          = yaw_reg;
    assign airspeed     = airspeed_reg;
    assign longitude    = longitude_reg;
    assign latitude     = latitude_reg;
    assign altitude     = altitude_reg;
    assign ground_speed = ground_speed_reg;
    assign course       = course_reg;

endmodule

>>> hdl/ifgd_checker.sv
// port-level checks for imu_gps_frame_decoder_unit, attached by bind
// depends on ifgd_pkg
module ifgd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         event_res,
    input logic signed [15:0] roll,
    input logic signed [15:0] pitch,
    input logic signed [15:0] yaw,
    input logic signed [15:0] airspeed,
    input logic signed [31:0] longitude,
    input logic signed [31:0] latitude,
    input logic signed [15:0] altitude,
    input logic signed [15:0] ground_speed,
    input logic signed [15:0] course
);

    // a result beat waiting for the sink stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked result");

    // plain attitude always reports airspeed as minus one
    a_att_airspeed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == ifgd_pkg::EV_ATT |-> airspeed == -16'sd1)
        else $error("attitude beat without airspeed marker");

    // attitude fields stay zero outside attitude events
    a_att_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != ifgd_pkg::EV_ATT && event_res != ifgd_pkg::EV_ATT_AS
        |-> roll == 0 && pitch == 0 && yaw == 0 && airspeed == 0)
        else $error("attitude fields set on a non-attitude beat");

    // gps fields stay zero outside gps events
    a_gps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != ifgd_pkg::EV_GPS
        |-> longitude == 0 && latitude == 0 && altitude == 0
            && ground_speed == 0 && course == 0)
        else $error("gps fields set on a non-gps beat");

endmodule

bind imu_gps_frame_decoder_unit ifgd_checker u_ifgd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .roll         (roll),
    .pitch        (pitch),
    .yaw          (yaw),
    .airspeed     (airspeed),
    .longitude    (longitude),
    .latitude     (latitude),
    .altitude     (altitude),
    .ground_speed (ground_speed),
    .course       (course)
);

>>> verif/imu_gps_frame_decoder_unit_tb.sv
// self-checking testbench for imu_gps_frame_decoder_unit: byte-level parse predictor,
// randomized valid/ready pacing on both sides, field-by-field check of every frame report
// depends on ifgd_pkg and the rtl under hdl
`timescale 1ns / 1ps

module imu_gps_frame_decoder_unit_tb;

    typedef struct {
        logic [7:0] data;
        int         gap;
    } rx_item_t;

    typedef struct {
        ifgd_pkg::event_t   ev;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] airspeed;
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [15:0] altitude;
        logic signed [15:0] ground_speed;
        logic signed [15:0] course;
    } frame_report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         event_res;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] airspeed;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [15:0] altitude;
    logic signed [15:0] ground_speed;
    logic signed [15:0] course;

    imu_gps_frame_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .roll         (roll),
        .pitch        (pitch),
        .yaw          (yaw),
        .airspeed     (airspeed),
        .longitude    (longitude),
        .latitude     (latitude),
        .altitude     (altitude),
        .ground_speed (ground_speed),
        .course       (course)
    );

    rx_item_t      rx_backlog[$];
    frame_report_t pending_reports[$];
    logic [7:0]    frame_body[ifgd_pkg::MAX_PAYLOAD];

    int  errors = 0;
    int  bytes_taken = 0;
    int  reports_seen = 0;
    int  ev_count[8];
    bit  in_calm = 1'b0;
    bit  out_calm = 1'b0;
    bit  in_beat = 1'b0;
    bit  out_beat = 1'b0;
    int  in_hold = 0;
    int  out_stall = 0;

    // parser shadow state
    ifgd_pkg::phase_t ph = ifgd_pkg::PH_HUNT;
    logic [4:0]       flen = '0;
    int               pidx = 0;
    logic [7:0]       mkind = '0;
    logic [7:0]       sum_lo = '0;
    logic [7:0]       sum_hi = '0;
    logic [7:0]       chk0 = '0;
    logic [7:0]       pay_mem[ifgd_pkg::MAX_PAYLOAD];

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL imu_gps_frame_decoder_unit");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic frame_report_t zero_report();
        frame_report_t r;
        r.ev           = ifgd_pkg::EV_ATT;
        r.roll         = '0;
        r.pitch        = '0;
        r.yaw          = '0;
        r.airspeed     = '0;
        r.longitude    = '0;
        r.latitude     = '0;
        r.altitude     = '0;
        r.ground_speed = '0;
        r.course       = '0;
        return r;
    endfunction

    function automatic void fold_sum(input logic [7:0] b);
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
    endfunction

    function automatic void rehunt();
        ph     = ifgd_pkg::PH_HUNT;
        pidx   = 0;
        sum_lo = '0;
        sum_hi = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        frame_report_t r;
        r = zero_report();
        case (ph)
            ifgd_pkg::PH_HDR1:
                ph = (b == ifgd_pkg::HDR1) ? ifgd_pkg::PH_HDR2 : ifgd_pkg::PH_HUNT;
            ifgd_pkg::PH_HDR2:
                ph = (b == ifgd_pkg::HDR2) ? ifgd_pkg::PH_HDR3 : ifgd_pkg::PH_HUNT;
            ifgd_pkg::PH_HDR3:
                ph = (b == ifgd_pkg::HDR3) ? ifgd_pkg::PH_LEN : ifgd_pkg::PH_HUNT;
            ifgd_pkg::PH_LEN:
            begin
                if (b > ifgd_pkg::MAX_PAYLOAD) begin
                    r.ev = ifgd_pkg::EV_LEN_ERR;
                    pending_reports.push_back(r);
                    rehunt();
                end else begin
                    flen = b[4:0];
                    fold_sum(b);
                    ph = ifgd_pkg::PH_MSG;
                end
            end
            ifgd_pkg::PH_MSG:
            begin
                mkind = b;
                fold_sum(b);
                ph = ifgd_pkg::PH_PAY;
            end
            ifgd_pkg::PH_PAY:
            begin
                if (pidx < ifgd_pkg::MAX_PAYLOAD)
                    pay_mem[pidx] = b;
                fold_sum(b);
                pidx++;
                // zero length still eats one payload byte
                if (pidx >= flen)
                    ph = ifgd_pkg::PH_CHK0;
            end
            ifgd_pkg::PH_CHK0:
            begin
                chk0 = b;
                ph = ifgd_pkg::PH_CHK1;
            end
            ifgd_pkg::PH_CHK1:
            begin
                if (sum_lo != chk0 || sum_hi != b) begin
                    r.ev = ifgd_pkg::EV_CHK_ERR;
                end else if (mkind == ifgd_pkg::MSG_ATT || mkind == ifgd_pkg::MSG_ATT_AS) begin
                    r.ev    = (mkind == ifgd_pkg::MSG_ATT) ? ifgd_pkg::EV_ATT
                                                           : ifgd_pkg::EV_ATT_AS;
                    r.roll  = {pay_mem[0], pay_mem[1]};
                    r.pitch = {pay_mem[2], pay_mem[3]};
                    r.yaw   = {pay_mem[4], pay_mem[5]};
                    r.airspeed = (mkind == ifgd_pkg::MSG_ATT) ? 16'hFFFF
                                                              : {pay_mem[6], pay_mem[7]};
                end else if (mkind == ifgd_pkg::MSG_GPS) begin
                    r.ev           = ifgd_pkg::EV_GPS;
                    r.longitude    = {pay_mem[0], pay_mem[1], pay_mem[2], pay_mem[3]};
                    r.latitude     = {pay_mem[4], pay_mem[5], pay_mem[6], pay_mem[7]};
                    r.altitude     = {pay_mem[8], pay_mem[9]};
                    r.ground_speed = {pay_mem[10], pay_mem[11]};
                    r.course       = {pay_mem[12], pay_mem[13]};
                end else if (mkind == ifgd_pkg::MSG_PERF) begin
                    r.ev = ifgd_pkg::EV_PERF;
                end else begin
                    r.ev = ifgd_pkg::EV_UNKNOWN;
                end
                pending_reports.push_back(r);
                rehunt();
            end
            default: ph = (b == ifgd_pkg::HDR0) ? ifgd_pkg::PH_HDR1 : ifgd_pkg::PH_HUNT;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int draw_in_gap();
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        return in_calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic int draw_out_stall();
        if ($urandom_range(0, 11) == 0)
            out_calm = !out_calm;
        return out_calm ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic put(input logic [7:0] b);
        rx_item_t it;
        it.data = b;
        it.gap  = draw_in_gap();
        rx_backlog.push_back(it);
    endtask

    // first 14 bytes big-endian from v, the rest set to fill
    task automatic load_body(input logic [111:0] v, input logic [7:0] fill);
        for (int i = 0; i < ifgd_pkg::MAX_PAYLOAD; i++)
            frame_body[i] = (i < 14) ? v[(13 - i) * 8 +: 8] : fill;
    endtask

    task automatic random_body();
        for (int i = 0; i < ifgd_pkg::MAX_PAYLOAD; i++) begin
            case ($urandom_range(0, 7))
                0: frame_body[i] = 8'h00;
                1: frame_body[i] = 8'hFF;
                2: frame_body[i] = 8'h80;
                3: frame_body[i] = 8'h7F;
                default: frame_body[i] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] msg, input bit spoil);
        logic [7:0] s1;
        logic [7:0] s2;
        int         n;
        s1 = '0;
        s2 = '0;
        n  = (len == 0) ? 1 : len;
        put(ifgd_pkg::HDR0);
        put(ifgd_pkg::HDR1);
        put(ifgd_pkg::HDR2);
        put(ifgd_pkg::HDR3);
        put(len);
        s1 = s1 + len;
        s2 = s2 + s1;
        put(msg);
        s1 = s1 + msg;
        s2 = s2 + s1;
        for (int i = 0; i < n; i++) begin
            put(frame_body[i]);
            s1 = s1 + frame_body[i];
            s2 = s2 + s1;
        end
        if (spoil) begin
            if ($urandom_range(0, 1) == 1)
                s1 = s1 ^ 8'($urandom_range(1, 255));
            else
                s2 = s2 ^ 8'($urandom_range(1, 255));
        end
        put(s1);
        put(s2);
    endtask

    task automatic send_bad_length(input logic [7:0] len);
        put(ifgd_pkg::HDR0);
        put(ifgd_pkg::HDR1);
        put(ifgd_pkg::HDR2);
        put(ifgd_pkg::HDR3);
        put(len);
    endtask

    // ---------------- driver and monitors ----------------

    always @(negedge clk) begin : rx_driver
        rx_item_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_hold  <= 0;
        end else if (!in_valid || in_beat) begin
            if (in_hold != 0) begin
                in_valid <= 1'b0;
                in_hold  <= in_hold - 1;
            end else if (rx_backlog.size() != 0) begin
                nxt = rx_backlog.pop_front();
                rx_byte  <= nxt.data;
                in_valid <= 1'b1;
                in_hold  <= nxt.gap;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // stall counts down only while a result is offered
    always @(negedge clk) begin : tx_ready
        int st;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else if (out_beat) begin
            st = draw_out_stall();
            out_stall <= st;
            out_ready <= (st == 0);
        end else if (out_valid && out_stall != 0) begin
            out_stall <= out_stall - 1;
            out_ready <= (out_stall == 1);
        end else begin
            out_ready <= (out_stall == 0);
        end
    end

    always @(posedge clk) begin : rx_monitor
        in_beat <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            parse_byte(rx_byte);
            bytes_taken++;
        end
    end

    function automatic void compare_field(input string nm, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", nm, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : tx_monitor
        frame_report_t want;
        out_beat <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result beat, event_res %0d", event_res);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("event_res", {29'd0, want.ev}, {29'd0, event_res});
                compare_field("roll", 32'(want.roll), 32'(roll));
                compare_field("pitch", 32'(want.pitch), 32'(pitch));
                compare_field("yaw", 32'(want.yaw), 32'(yaw));
                compare_field("airspeed", 32'(want.airspeed), 32'(airspeed));
                compare_field("longitude", want.longitude, longitude);
                compare_field("latitude", want.latitude, latitude);
                compare_field("altitude", 32'(want.altitude), 32'(altitude));
                compare_field("ground_speed", 32'(want.ground_speed), 32'(ground_speed));
                compare_field("course", 32'(want.course), 32'(course));
                reports_seen++;
                if (!$isunknown(event_res))
                    ev_count[event_res]++;
            end
        end
    end

    // ---------------- test sequence ----------------

    initial begin : stimulus
        int         target;
        int         spins;
        int         cut;
        logic [7:0] msg;
        logic [7:0] len;

        for (int i = 0; i < ifgd_pkg::MAX_PAYLOAD; i++)
            pay_mem[i] = '0;
        for (int i = 0; i < 8; i++)
            ev_count[i] = 0;

        // directed frames: field extremes, every message kind, error paths
        load_body(112'h7FFF_8000_FFFF_0000_0000_0000_0000, 8'h00);
        send_frame(8'd6, ifgd_pkg::MSG_ATT, 1'b0);
        load_body(112'h8000_7FFF_0001_8000_0000_0000_0000, 8'h00);
        send_frame(8'd8, ifgd_pkg::MSG_ATT_AS, 1'b0);
        load_body(112'h8000_0000_7FFF_FFFF_8000_7FFF_FFFF, 8'h00);
        send_frame(8'd14, ifgd_pkg::MSG_GPS, 1'b0);
        load_body({112{1'b1}}, 8'hFF);
        send_frame(8'd28, ifgd_pkg::MSG_PERF, 1'b0);
        load_body(112'h1122_3344_5566_7788_0000_0000_0000, 8'h00);
        send_frame(8'd8, ifgd_pkg::MSG_ATT, 1'b1);
        load_body(112'hA500_0000_0000_0000_0000_0000_0000, 8'h00);
        send_frame(8'd0, 8'hFF, 1'b0);
        send_frame(8'd1, 8'h00, 1'b0);
        // short gps frame decodes stale store bytes
        load_body(112'h1234_0000_0000_0000_0000_0000_0000, 8'h00);
        send_frame(8'd2, ifgd_pkg::MSG_GPS, 1'b0);
        send_bad_length(8'd29);
        send_bad_length(8'd255);
        // header breaks at each position, second 0x44 is not a new start
        put(ifgd_pkg::HDR0); put(8'h00);
        put(ifgd_pkg::HDR0); put(ifgd_pkg::HDR1); put(8'h00);
        put(ifgd_pkg::HDR0); put(ifgd_pkg::HDR1); put(ifgd_pkg::HDR2); put(8'h00);
        put(ifgd_pkg::HDR0); put(ifgd_pkg::HDR0); put(ifgd_pkg::HDR1);
        put(ifgd_pkg::HDR2); put(ifgd_pkg::HDR3);
        load_body(112'h0102_0304_0506_0708_0000_0000_0000, 8'h00);
        send_frame(8'd8, ifgd_pkg::MSG_ATT_AS, 1'b0);

        target = 1650;
        while (rx_backlog.size() < target) begin
            random_body();
            case ($urandom_range(0, 5))
                0: msg = ifgd_pkg::MSG_ATT;
                1: msg = ifgd_pkg::MSG_ATT_AS;
                2: msg = ifgd_pkg::MSG_GPS;
                3: msg = ifgd_pkg::MSG_PERF;
                default: msg = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 9) < 7
                && (msg == ifgd_pkg::MSG_ATT || msg == ifgd_pkg::MSG_ATT_AS))
                len = 8'd8;
            else if ($urandom_range(0, 9) < 7 && msg == ifgd_pkg::MSG_GPS)
                len = 8'd14;
            else if ($urandom_range(0, 5) == 0)
                len = ($urandom_range(0, 1) == 1) ? 8'd28 : 8'd0;
            else
                len = 8'($urandom_range(0, 28));

            case ($urandom_range(0, 99)) inside
                [0:64]:  send_frame(len, msg, 1'b0);
                [65:76]: send_frame(len, msg, 1'b1);
                [77:84]:
                begin
                    // runs of short frames build up pressure on the result side
                    repeat ($urandom_range(1, 3))
                        send_bad_length(8'($urandom_range(29, 255)));
                end
                [85:90]:
                begin
                    put(ifgd_pkg::HDR0);
                    if ($urandom_range(0, 1) == 1)
                        put(ifgd_pkg::HDR1);
                    put(8'($urandom_range(0, 255)));
                end
                [91:95]:
                begin
                    repeat ($urandom_range(1, 6))
                        put(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    // cut-off frame, whatever follows gets parsed as its payload
                    put(ifgd_pkg::HDR0); put(ifgd_pkg::HDR1);
                    put(ifgd_pkg::HDR2); put(ifgd_pkg::HDR3);
                    put(len);
                    put(msg);
                    cut = $urandom_range(0, 4);
                    for (int i = 0; i < cut; i++)
                        put(frame_body[i]);
                end
            endcase
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (rx_backlog.size() != 0 || in_valid)
            @(negedge clk);
        spins = 0;
        while (pending_reports.size() != 0 && spins < 5000) begin
            @(negedge clk);
            spins++;
        end
        repeat (20) @(negedge clk);
        if (pending_reports.size() != 0) begin
            $error("%0d frame reports never arrived", pending_reports.size());
            errors += pending_reports.size();
        end

        $display("%0d bytes parsed, %0d frame reports checked", bytes_taken, reports_seen);
        $display("att %0d, att+airspeed %0d, gps %0d, perf %0d, unknown %0d",
                 ev_count[ifgd_pkg::EV_ATT], ev_count[ifgd_pkg::EV_ATT_AS],
                 ev_count[ifgd_pkg::EV_GPS], ev_count[ifgd_pkg::EV_PERF],
                 ev_count[ifgd_pkg::EV_UNKNOWN]);
        $display("bad sum %0d, bad len %0d",
                 ev_count[ifgd_pkg::EV_CHK_ERR], ev_count[ifgd_pkg::EV_LEN_ERR]);
        if (errors == 0)
            $display("PASS imu_gps_frame_decoder_unit");
        else
            $display("FAIL imu_gps_frame_decoder_unit");
        $finish;
    end

endmodule
